// ===== design/pcxd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcxd_pkg
// Shared types and constants for the PCX run-length scanline decoder.
// ----------------------------------------------------------------------------
package pcxd_pkg;

  localparam int COORD_BITS = 16;
  localparam int FIELD_BITS = 16;
  localparam int CFG_DATA_BITS = 16;
  localparam int LEFT_BITS = COORD_BITS + 3;

  localparam logic [7:0] RUN_MARK = 8'hC0;
  localparam logic [7:0] RUN_COUNT = 8'h3F;
  localparam logic [5:0] RUN_ONE = 6'h01;

  typedef enum logic [1:0] {
    CFG_WIDTH_M1  = 2'd0,
    CFG_HEIGHT_M1 = 2'd1,
    CFG_PLANES    = 2'd2,
    CFG_RLE       = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] width_m1;
    logic [COORD_BITS-1:0] height_m1;
    logic                  three_planes;
  } geom_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;
    logic [1:0]            chan;
    logic                  step_done;
    logic [LEFT_BITS-1:0]  bytes_left;
  } pos_status_t;

endpackage : pcxd_pkg
`default_nettype wire

// ===== design/pcxd_pos_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcxd_pos_unit
// Position counter shared by literals and run bytes: column, plane and row,
// one byte step per cycle when stepped, plus bytes left in the current row.
// ----------------------------------------------------------------------------
module pcxd_pos_unit (
  input  wire                  clk,
  input  wire                  rst,
  input  wire pcxd_pkg::geom_t geom,
  input  wire                  step,
  output pcxd_pkg::pos_status_t status
);
  import pcxd_pkg::*;

  logic [COORD_BITS-1:0] col;
  logic [COORD_BITS-1:0] row;
  logic [1:0]            plane;
  logic [COORD_BITS-1:0] col_next;
  logic [COORD_BITS-1:0] row_next;
  logic [1:0]            plane_next;
  logic                  done;

  logic [1:0]            last_plane;
  logic [1:0]            plane_clamp;
  logic [1:0]            planes_after;
  logic [COORD_BITS-1:0] col_clamp;
  logic [COORD_BITS:0]   row_bytes;
  logic [LEFT_BITS-1:0]  tail_bytes;
  logic [LEFT_BITS-1:0]  plane_bytes;

  always_comb begin
    last_plane = geom.three_planes ? 2'd2 : 2'd0;
    col_next   = col;
    plane_next = plane;
    row_next   = row;
    done       = 1'b0;
    if (col >= geom.width_m1) begin
      col_next = '0;
      if (plane >= last_plane) begin
        plane_next = '0;
        if (row >= geom.height_m1) begin
          done = 1'b1;
        end else begin
          row_next = row + 1'b1;
        end
      end else begin
        plane_next = plane + 1'b1;
      end
    end else begin
      col_next = col + 1'b1;
    end
  end

  // bytes left in row, position clamped to the current geometry
  always_comb begin
    plane_clamp  = (plane > last_plane) ? last_plane : plane;
    planes_after = last_plane - plane_clamp;
    col_clamp    = (col > geom.width_m1) ? geom.width_m1 : col;
    row_bytes    = {1'b0, geom.width_m1} + 1'b1;
    tail_bytes   = LEFT_BITS'(row_bytes) - LEFT_BITS'(col_clamp);
    case (planes_after)
      2'd1:    plane_bytes = LEFT_BITS'(row_bytes);
      2'd2:    plane_bytes = LEFT_BITS'({row_bytes, 1'b0});
      default: plane_bytes = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col   <= '0;
      row   <= '0;
      plane <= '0;
    end else if (step) begin
      col   <= col_next;
      row   <= row_next;
      plane <= plane_next;
    end
  end

  always_comb begin
    status.row        = row;
    status.col        = col;
    status.chan       = geom.three_planes ? (2'd2 - ((plane > 2'd2) ? 2'd2 : plane)) : 2'd0;
    status.step_done  = done;
    status.bytes_left = plane_bytes + tail_bytes;
  end

endmodule : pcxd_pos_unit
`default_nettype wire

// ===== design/pcx_rle_scanline_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcx_rle_scanline_decoder
// Decodes the PCX image byte stream into positioned pixel channel bytes.
// ----------------------------------------------------------------------------
// One data word is taken per cycle while the block is idle and the result
// register is free. A literal gives one result word in the cycle after it is
// taken; a run header gives none, or an error word if its count exceeds the
// bytes left in the row; a run value gives N words, one per cycle while the
// result register is free, with in_ready low. The rate is set by the single
// position counter, one byte per cycle when stepped, and the one-deep result
// register. After the last row or a run that overflows its row, input words
// are still taken but give nothing until reset. The user must write geometry
// and mode through the cfg port while the block is idle; it is not enforced.
module pcx_rle_scanline_decoder (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   cfg_write_en,
  input  wire  [1:0]                            cfg_index,
  input  wire  [pcxd_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire  [7:0]                            data_byte,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic [7:0]                            pixel_value,
  output logic [pcxd_pkg::FIELD_BITS-1:0]       row_index,
  output logic [pcxd_pkg::FIELD_BITS-1:0]       column_index,
  output logic [1:0]                            channel_offset,
  output logic                                  last_of_run,
  output logic                                  image_done,
  output logic                                  decode_error
);
  import pcxd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t      state;
  geom_t       geom;
  logic        rle_enabled;
  pos_status_t pos;

  logic [7:0] run_value;
  logic [5:0] run_left;
  logic       awaiting;
  logic [5:0] pending;
  logic       img_complete;
  logic       err_latched;

  logic       slot_free;
  logic       in_fire;
  logic       live;
  logic       is_header;
  logic [5:0] byte_cnt;
  logic       too_long;
  logic       emit_lit;
  logic       emit_err;
  logic       arm;
  logic       take_val;
  logic       run_emit;
  logic       step;
  logic       load;

  pcxd_pos_unit u_pos (
    .clk    (clk),
    .rst    (rst),
    .geom   (geom),
    .step   (step),
    .status (pos)
  );

  always_comb begin
    slot_free = !out_valid || out_ready;
    in_ready  = (state == ST_IDLE) && slot_free;
    in_fire   = in_valid && in_ready;
    live      = !err_latched && !img_complete;
    is_header = rle_enabled && ((data_byte & RUN_MARK) == RUN_MARK);
    byte_cnt  = 6'(data_byte & RUN_COUNT);
    too_long  = LEFT_BITS'(byte_cnt) > pos.bytes_left;
    take_val  = in_fire && live && awaiting;
    emit_lit  = in_fire && live && !awaiting && !is_header;
    emit_err  = in_fire && live && !awaiting && is_header && too_long;
    arm       = in_fire && live && !awaiting && is_header && !too_long;
    run_emit  = (state == ST_RUN) && slot_free;
    step      = emit_lit || run_emit;
    load      = step || emit_err;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      geom        <= '0;
      rle_enabled <= 1'b1;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_WIDTH_M1:  geom.width_m1     <= cfg_data[COORD_BITS-1:0];
        CFG_HEIGHT_M1: geom.height_m1    <= cfg_data[COORD_BITS-1:0];
        CFG_PLANES:    geom.three_planes <= cfg_data[0];
        CFG_RLE:       rle_enabled       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      run_left     <= '0;
      awaiting     <= 1'b0;
      pending      <= '0;
      img_complete <= 1'b0;
      err_latched  <= 1'b0;
    end else begin
      if (arm) begin
        awaiting <= 1'b1;
        pending  <= byte_cnt;
      end
      if (take_val) begin
        awaiting <= 1'b0;
        pending  <= '0;
        run_left <= pending;
        if (pending != '0) begin
          state <= ST_RUN;
        end
      end
      if (run_emit) begin
        run_left <= run_left - 1'b1;
        if (run_left == RUN_ONE || pos.step_done) begin
          state <= ST_IDLE;
        end
      end
      if (emit_err) begin
        err_latched <= 1'b1;
      end
      if (step && pos.step_done) begin
        img_complete <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_val) begin
      run_value <= data_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixel_value    <= emit_err ? 8'd0 : (emit_lit ? data_byte : run_value);
      row_index      <= FIELD_BITS'(pos.row);
      column_index   <= FIELD_BITS'(pos.col);
      channel_offset <= pos.chan;
      last_of_run    <= emit_lit || emit_err || (run_left == RUN_ONE);
      image_done     <= step && pos.step_done;
      decode_error   <= emit_err;
    end
  end

endmodule : pcx_rle_scanline_decoder
`default_nettype wire
